// ----- sv/idmf_pkg.sv -----
// Shared constants and types for the infrared distance median filter.
package idmf_pkg;

	localparam int WINDOW_DEPTH  = 5;
	localparam int FRACTION_BITS = 8;
	localparam int CHANNELS      = 3;

	localparam int RAW_W  = 10;
	localparam int DIST_W = 16;
	localparam int DIV_W  = DIST_W + FRACTION_BITS;

	localparam int IN_DATA_W  = ((CHANNELS * RAW_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((CHANNELS * DIST_W + 7) / 8) * 8;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_RAW_FLOOR        = 2'd0;
	localparam logic [1:0] REG_RAW_OFFSET       = 2'd1;
	localparam logic [1:0] REG_DISTANCE_SCALE   = 2'd2;
	localparam logic [1:0] REG_DISTANCE_CEILING = 2'd3;

	localparam logic [RAW_W-1:0]  RAW_FLOOR_RST        = RAW_W'(160);
	localparam logic [RAW_W-1:0]  RAW_OFFSET_RST       = RAW_W'(80);
	localparam logic [DIST_W-1:0] DISTANCE_SCALE_RST   = DIST_W'(6200);
	localparam logic [DIST_W-1:0] DISTANCE_CEILING_RST = DIST_W'(17920);

	typedef logic [RAW_W-1:0]  raw_t;
	typedef logic [DIST_W-1:0] dist_t;

endpackage

// ----- sv/ir_distance_median_filter.sv -----
// Top level: three-channel infrared distance conversion with sliding-window median.
//
// Usage. Items enter on the s_ stream (raw_front, raw_left, raw_right packed in
// s_tdata) and one result item leaves on the m_ stream per input item, holding the
// median distances in Q8.8 centimetres. The APB port sets the floor, offset, scale
// and ceiling registers; write them only while the block is idle.
//
// Timing. The three channels share one restoring divider that yields one quotient
// bit per cycle, and one median unit that takes one window entry per cycle as a
// candidate. Each channel in turn passes through setup, division (skipped when the
// difference is not positive), clamp, window push, median pass and rotation; a new
// item is taken only after all three results have moved to the output register.
//
// The result sits in an output register: once the core has handed it over, the
// next item is accepted at once and worked on even if the receiver stalls; the
// core then holds its finished result until the output register frees up.
//
// Reset clears the registers to their defaults, the last medians to zero and the
// primed flag, so the first item after reset fills the whole window.
module ir_distance_median_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata: raw_front [9:0], raw_left [19:10], raw_right [29:20], zero pad
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [idmf_pkg::IN_DATA_W-1:0]     s_tdata,
	// m_tdata: dist_front [15:0], dist_left [31:16], dist_right [47:32]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [idmf_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [idmf_pkg::ADDR_W-1:0]        paddr,
	input  logic [idmf_pkg::DATA_W-1:0]        pwdata,
	output logic [idmf_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import idmf_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int MCNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int K_LO   = (WINDOW_DEPTH - 1) / 2;
	localparam int K_HI   = WINDOW_DEPTH / 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_DIV,
		S_CLAMP,
		S_PUSH,
		S_MED,
		S_NEXT,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	raw_t  raw_floor_q;
	raw_t  raw_offset_q;
	dist_t distance_scale_q;
	dist_t distance_ceiling_q;

	logic             cfg_wr;
	logic [1:0]       cfg_idx;

	// Control
	logic [CH_W-1:0]   chan_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic              primed_q;
	logic              out_vld_q;
	logic [OUT_DATA_W-1:0] out_q;
	dist_t             last_med_q [CHANNELS];

	// Datapath
	raw_t              raw_q   [CHANNELS];
	logic [DIV_W-1:0]  dvd_q;
	raw_t              div_q;
	raw_t              rem_q;
	dist_t             dist_q;
	dist_t             work_q  [WINDOW_DEPTH];
	dist_t             win_q   [CHANNELS][WINDOW_DEPTH];
	dist_t             m_lo_q;
	dist_t             m_hi_q;
	dist_t             res_q   [CHANNELS];

	logic              in_acc;
	logic              out_load;
	raw_t              raw_sel;
	logic              trivial;
	raw_t              diff;
	logic [RAW_W:0]    rem_sh;
	logic              q_bit;
	logic [RAW_W:0]    rem_nx;
	dist_t             dist_cl;
	dist_t             dist_nz;
	logic [WINDOW_DEPTH-1:0] lt_vec;
	logic [WINDOW_DEPTH-1:0] le_vec;
	logic [MCNT_W-1:0] lt_cnt;
	logic [MCNT_W-1:0] le_cnt;
	logic [DIST_W:0]   med_sum;
	dist_t             med;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_comb begin
		case (cfg_idx)
			REG_RAW_FLOOR:        prdata = DATA_W'(raw_floor_q);
			REG_RAW_OFFSET:       prdata = DATA_W'(raw_offset_q);
			REG_DISTANCE_SCALE:   prdata = DATA_W'(distance_scale_q);
			REG_DISTANCE_CEILING: prdata = DATA_W'(distance_ceiling_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_floor_q        <= RAW_FLOOR_RST;
			raw_offset_q       <= RAW_OFFSET_RST;
			distance_scale_q   <= DISTANCE_SCALE_RST;
			distance_ceiling_q <= DISTANCE_CEILING_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RAW_FLOOR:        raw_floor_q        <= pwdata[RAW_W-1:0];
				REG_RAW_OFFSET:       raw_offset_q       <= pwdata[RAW_W-1:0];
				REG_DISTANCE_SCALE:   distance_scale_q   <= pwdata[DIST_W-1:0];
				REG_DISTANCE_CEILING: distance_ceiling_q <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!out_vld_q || m_tready);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// ---------------------------------------------------------------- conversion
	// The current channel always sits at index 0; the channel rows rotate by one
	// after each channel, so after all of them they are back in order.
	assign raw_sel = (raw_q[0] < raw_floor_q) ? raw_floor_q : raw_q[0];
	assign trivial = (raw_sel <= raw_offset_q);
	assign diff    = raw_sel - raw_offset_q;

	// One restoring division step: bring down the next dividend bit.
	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign q_bit  = (rem_sh >= {1'b0, div_q});
	assign rem_nx = q_bit ? (rem_sh - {1'b0, div_q}) : rem_sh;

	// Clamp to the ceiling; an inconclusive zero falls back to the last median.
	assign dist_cl = (dvd_q > DIV_W'(distance_ceiling_q)) ? distance_ceiling_q
		: dvd_q[DIST_W-1:0];
	assign dist_nz = (dist_cl == '0) ? last_med_q[0] : dist_cl;

	// ---------------------------------------------------------------- median
	// The candidate is work_q[0]; it is the k-th smallest when fewer than k+1
	// entries lie below it and more than k lie at or below it.
	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			lt_vec[i] = (work_q[i] <  work_q[0]);
			le_vec[i] = (work_q[i] <= work_q[0]);
		end
	end

	assign lt_cnt  = MCNT_W'($countones(lt_vec));
	assign le_cnt  = MCNT_W'($countones(le_vec));
	assign med_sum = {1'b0, m_lo_q} + {1'b0, m_hi_q};
	assign med     = med_sum[DIST_W:1];

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			chan_q    <= '0;
			dcnt_q    <= '0;
			mcnt_q    <= '0;
			primed_q  <= 1'b0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				last_med_q[c] <= '0;
			end
		end else begin
			// Load a new result, else drop the one the receiver has taken.
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						chan_q  <= '0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					dcnt_q  <= DCNT_W'(DIV_W);
					state_q <= trivial ? S_CLAMP : S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					mcnt_q  <= '0;
					state_q <= S_MED;
				end
				S_MED: begin
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == MCNT_W'(WINDOW_DEPTH - 1)) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					for (int c = 0; c < CHANNELS - 1; c++) begin
						last_med_q[c] <= last_med_q[c+1];
					end
					last_med_q[CHANNELS-1] <= med;
					if (chan_q == CH_W'(CHANNELS - 1)) begin
						chan_q  <= '0;
						state_q <= S_DONE;
					end else begin
						chan_q  <= chan_q + 1'b1;
						state_q <= S_SETUP;
					end
				end
				S_DONE: begin
					// Hold the result until the output register is free.
					if (out_load) begin
						for (int c = 0; c < CHANNELS; c++) begin
							out_q[c*DIST_W +: DIST_W] <= res_q[c];
						end
						primed_q  <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					for (int c = 0; c < CHANNELS; c++) begin
						raw_q[c] <= s_tdata[c*RAW_W +: RAW_W];
					end
				end
			end
			S_SETUP: begin
				rem_q <= '0;
				div_q <= diff;
				// A non-positive difference gives the ceiling straight away.
				dvd_q <= trivial ? DIV_W'(distance_ceiling_q)
					: (DIV_W'(distance_scale_q) << FRACTION_BITS);
			end
			S_DIV: begin
				rem_q <= rem_nx[RAW_W-1:0];
				dvd_q <= {dvd_q[DIV_W-2:0], q_bit};
			end
			S_CLAMP: begin
				dist_q <= dist_nz;
			end
			S_PUSH: begin
				// Fill the whole window on the first item, else slide it by one.
				for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
					work_q[i] <= primed_q ? win_q[0][i+1] : dist_q;
				end
				work_q[WINDOW_DEPTH-1] <= dist_q;
			end
			S_MED: begin
				if ((lt_cnt <= MCNT_W'(K_LO)) && (le_cnt > MCNT_W'(K_LO))) begin
					m_lo_q <= work_q[0];
				end
				if ((lt_cnt <= MCNT_W'(K_HI)) && (le_cnt > MCNT_W'(K_HI))) begin
					m_hi_q <= work_q[0];
				end
				// Rotate; after a full pass the row is back in order.
				for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
					work_q[i] <= work_q[i+1];
				end
				work_q[WINDOW_DEPTH-1] <= work_q[0];
			end
			S_NEXT: begin
				for (int c = 0; c < CHANNELS - 1; c++) begin
					raw_q[c] <= raw_q[c+1];
					res_q[c] <= res_q[c+1];
					for (int i = 0; i < WINDOW_DEPTH; i++) begin
						win_q[c][i] <= win_q[c+1][i];
					end
				end
				raw_q[CHANNELS-1] <= raw_q[0];
				res_q[CHANNELS-1] <= med;
				for (int i = 0; i < WINDOW_DEPTH; i++) begin
					win_q[CHANNELS-1][i] <= work_q[i];
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- checks
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_q != '0))
		else $error("divider running with a zero divisor");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_q <= CH_W'(CHANNELS - 1)))
		else $error("channel counter out of range");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_SETUP) && (chan_q == '0))
		else $error("accepted item did not start conversion");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready && (state_q == S_DONE)) |=> (state_q == S_DONE))
		else $error("result dropped while the output register was full");

endmodule
